// ----- rtl/rpnsm_pkg.sv -----
// shared types, codes and arithmetic helpers of the rpn stack machine
package rpnsm_pkg;

  localparam int MEM_WORDS_DEF   = 1024;
  localparam int STACK_DEPTH_DEF = 64;

  localparam int VAL_W  = 64;
  localparam int ADDR_W = 17;
  localparam int CFG_W  = 11;
  localparam int DIV_STEPS = 96;

  localparam logic [CFG_W-1:0]        CFG_RESET = 11'd1024;
  localparam logic signed [VAL_W-1:0] ONE_Q     = 64'sh0000_0001_0000_0000;
  localparam logic signed [VAL_W-1:0] Q_MAX     = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [VAL_W-1:0] Q_MIN     = 64'sh8000_0000_0000_0000;

  // request types
  localparam logic [2:0] RT_VAR   = 3'd0;
  localparam logic [2:0] RT_CONST = 3'd1;
  localparam logic [2:0] RT_STR   = 3'd2;
  localparam logic [2:0] RT_LABEL = 3'd3;
  localparam logic [2:0] RT_OP    = 3'd4;

  // operations
  localparam logic [4:0] OP_ADD    = 5'd0;
  localparam logic [4:0] OP_SUB    = 5'd1;
  localparam logic [4:0] OP_MUL    = 5'd2;
  localparam logic [4:0] OP_DIV    = 5'd3;
  localparam logic [4:0] OP_NEG    = 5'd4;
  localparam logic [4:0] OP_ASSIGN = 5'd5;
  localparam logic [4:0] OP_IDX    = 5'd6;
  localparam logic [4:0] OP_LT     = 5'd7;
  localparam logic [4:0] OP_GT     = 5'd8;
  localparam logic [4:0] OP_LE     = 5'd9;
  localparam logic [4:0] OP_GE     = 5'd10;
  localparam logic [4:0] OP_EQ     = 5'd11;
  localparam logic [4:0] OP_NE     = 5'd12;
  localparam logic [4:0] OP_JF     = 5'd13;
  localparam logic [4:0] OP_J      = 5'd14;
  localparam logic [4:0] OP_READ   = 5'd15;
  localparam logic [4:0] OP_PRINT  = 5'd16;

  // error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_EMPTY     = 3'd1;
  localparam logic [2:0] ERR_NEED_REF  = 3'd2;
  localparam logic [2:0] ERR_ADDR      = 3'd3;
  localparam logic [2:0] ERR_DIV_ZERO  = 3'd4;
  localparam logic [2:0] ERR_ARRAY_REF = 3'd5;
  localparam logic [2:0] ERR_READ_REF  = 3'd6;
  localparam logic [2:0] ERR_FULL      = 3'd7;

  typedef struct packed {
    logic signed [VAL_W-1:0] val;
    logic                    is_ref;
    logic                    is_str;
    logic [ADDR_W-1:0]       addr;
  } entry_t;

  typedef enum logic [2:0] {
    RES_VAR, RES_CONST, RES_STR, RES_LABEL, RES_ALU, RES_MUL, RES_DIV, RES_IDX
  } res_sel_t;

  typedef struct packed {
    logic       clear_step;
    logic       load_instr;
    logic       pop;
    logic       ent_load;
    logic       slot_load;
    logic       slot_sel;
    logic       slot_mem;
    logic       res_load;
    res_sel_t   res_sel;
    logic       push;
    logic       mul_start;
    logic       mul_step;
    logic       div_start;
    logic       div_step;
    logic       mem_write;
    logic       mem_src_read;
    logic       set_err;
    logic [2:0] err_code;
    logic       jump;
    logic       print_str;
    logic       print_num;
    logic       print_mem;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic [4:0] opcode;
    logic       halted;
    logic       stack_empty;
    logic       stack_full;
    logic       ent_ref;
    logic       ent_str;
    logic       ent_ok;
    logic       v1_zero;
    logic       v2_zero;
    logic       idx_ok;
    logic       mul_last;
    logic       div_last;
    logic       clear_last;
    logic       out_free;
  } status_t;

  function automatic logic [VAL_W-1:0] magnitude(input logic [VAL_W-1:0] v);
    return v[VAL_W-1] ? (~v + 64'd1) : v;
  endfunction

  // signed result from magnitude and sign, saturating
  function automatic logic signed [VAL_W-1:0] from_mag(input logic [VAL_W-1:0] mag,
                                                       input logic neg, input logic ovf);
    logic signed [VAL_W-1:0] r;
    if (neg) begin
      r = (ovf || mag[VAL_W-1]) ? Q_MIN : $signed(~mag + 64'd1);
    end else begin
      r = (ovf || mag[VAL_W-1]) ? Q_MAX : $signed(mag);
    end
    return r;
  endfunction

  function automatic logic signed [VAL_W-1:0] sat65(input logic [VAL_W:0] s);
    logic signed [VAL_W-1:0] r;
    if (s[VAL_W] != s[VAL_W-1]) begin
      r = s[VAL_W] ? Q_MIN : Q_MAX;
    end else begin
      r = $signed(s[VAL_W-1:0]);
    end
    return r;
  endfunction

  // integer part, truncated toward zero
  function automatic logic signed [31:0] int_part(input logic [VAL_W-1:0] v);
    return $signed(v[63:32] + {31'd0, v[63] & (|v[31:0])});
  endfunction

endpackage

// ----- rtl/rpnsm_ram.sv -----
// generic single write, single read ram with registered read data
module rpnsm_ram #(
  parameter int W = 64,
  parameter int D = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/rpnsm_ctrl.sv -----
// sequencing state machine of the rpn stack machine
module rpnsm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  rpnsm_pkg::status_t  status,
  output rpnsm_pkg::cmd_t     cmd
);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DECODE, ST_POP, ST_POPW, ST_CHECK, ST_MEMW, ST_EXEC,
    ST_MUL, ST_MULF, ST_DIV, ST_DIVF, ST_PMEM, ST_PUSH, ST_FIN
  } state_t;

  state_t state, state_next;
  logic   pop_n, pop_n_next;
  logic   entry_pop;
  logic   two_pops;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    entry_pop = (status.opcode == rpnsm_pkg::OP_READ) ||
                (status.opcode == rpnsm_pkg::OP_PRINT) ||
                (((status.opcode == rpnsm_pkg::OP_ASSIGN) ||
                  (status.opcode == rpnsm_pkg::OP_IDX)) && pop_n);
    two_pops  = status.opcode inside {rpnsm_pkg::OP_ADD, rpnsm_pkg::OP_SUB,
                rpnsm_pkg::OP_MUL, rpnsm_pkg::OP_DIV, rpnsm_pkg::OP_ASSIGN,
                rpnsm_pkg::OP_IDX, rpnsm_pkg::OP_LT, rpnsm_pkg::OP_GT, rpnsm_pkg::OP_LE,
                rpnsm_pkg::OP_GE, rpnsm_pkg::OP_EQ, rpnsm_pkg::OP_NE, rpnsm_pkg::OP_JF};
  end

  always_comb begin
    cmd        = '0;
    cmd.res_sel = rpnsm_pkg::RES_VAR;
    state_next = state;
    pop_n_next = pop_n;
    case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_instr = 1'b1;
          state_next     = ST_DECODE;
        end
      end
      ST_DECODE: begin
        pop_n_next = 1'b0;
        state_next = ST_PUSH;
        cmd.res_load = 1'b1;
        if (status.halted) begin
          cmd.res_load = 1'b0;
          state_next   = ST_FIN;
        end else begin
          case (status.req_type)
            rpnsm_pkg::RT_VAR:   cmd.res_sel = rpnsm_pkg::RES_VAR;
            rpnsm_pkg::RT_CONST: cmd.res_sel = rpnsm_pkg::RES_CONST;
            rpnsm_pkg::RT_STR:   cmd.res_sel = rpnsm_pkg::RES_STR;
            rpnsm_pkg::RT_LABEL: cmd.res_sel = rpnsm_pkg::RES_LABEL;
            rpnsm_pkg::RT_OP: begin
              cmd.res_load = 1'b0;
              state_next   = (status.opcode <= rpnsm_pkg::OP_PRINT) ? ST_POP : ST_FIN;
            end
            default: begin
              cmd.res_load = 1'b0;
              state_next   = ST_FIN;
            end
          endcase
        end
      end
      ST_POP: begin
        if (status.stack_empty) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = rpnsm_pkg::ERR_EMPTY;
          state_next   = ST_FIN;
        end else begin
          cmd.pop    = 1'b1;
          state_next = ST_POPW;
        end
      end
      ST_POPW: begin
        cmd.ent_load = 1'b1;
        state_next   = ST_CHECK;
      end
      ST_CHECK: begin
        if (entry_pop) begin
          state_next = ST_EXEC;
        end else if (status.ent_str || (status.ent_ref && !status.ent_ok)) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = rpnsm_pkg::ERR_ADDR;
          state_next   = ST_FIN;
        end else if (status.ent_ref) begin
          state_next = ST_MEMW;
        end else begin
          cmd.slot_load = 1'b1;
          cmd.slot_sel  = pop_n;
          if (two_pops && !pop_n) begin
            pop_n_next = 1'b1;
            state_next = ST_POP;
          end else begin
            state_next = ST_EXEC;
          end
        end
      end
      ST_MEMW: begin
        cmd.slot_load = 1'b1;
        cmd.slot_sel  = pop_n;
        cmd.slot_mem  = 1'b1;
        if (two_pops && !pop_n) begin
          pop_n_next = 1'b1;
          state_next = ST_POP;
        end else begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_FIN;
        case (status.opcode)
          rpnsm_pkg::OP_ADD, rpnsm_pkg::OP_SUB, rpnsm_pkg::OP_NEG, rpnsm_pkg::OP_LT,
          rpnsm_pkg::OP_GT, rpnsm_pkg::OP_LE, rpnsm_pkg::OP_GE, rpnsm_pkg::OP_EQ,
          rpnsm_pkg::OP_NE: begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = rpnsm_pkg::RES_ALU;
            state_next   = ST_PUSH;
          end
          rpnsm_pkg::OP_MUL: begin
            cmd.mul_start = 1'b1;
            state_next    = ST_MUL;
          end
          rpnsm_pkg::OP_DIV: begin
            if (status.v1_zero) begin
              cmd.set_err  = 1'b1;
              cmd.err_code = rpnsm_pkg::ERR_DIV_ZERO;
            end else begin
              cmd.div_start = 1'b1;
              state_next    = ST_DIV;
            end
          end
          rpnsm_pkg::OP_ASSIGN: begin
            if (!status.ent_ref) begin
              cmd.set_err  = 1'b1;
              cmd.err_code = rpnsm_pkg::ERR_NEED_REF;
            end else if (status.ent_str || !status.ent_ok) begin
              cmd.set_err  = 1'b1;
              cmd.err_code = rpnsm_pkg::ERR_ADDR;
            end else begin
              cmd.mem_write = 1'b1;
            end
          end
          rpnsm_pkg::OP_IDX: begin
            if (!status.ent_ref || status.ent_str) begin
              cmd.set_err  = 1'b1;
              cmd.err_code = rpnsm_pkg::ERR_ARRAY_REF;
            end else if (!status.idx_ok) begin
              cmd.set_err  = 1'b1;
              cmd.err_code = rpnsm_pkg::ERR_ADDR;
            end else begin
              cmd.res_load = 1'b1;
              cmd.res_sel  = rpnsm_pkg::RES_IDX;
              state_next   = ST_PUSH;
            end
          end
          rpnsm_pkg::OP_JF: begin
            cmd.jump = status.v2_zero;
          end
          rpnsm_pkg::OP_J: begin
            cmd.jump = 1'b1;
          end
          rpnsm_pkg::OP_READ: begin
            if (!status.ent_ref || status.ent_str) begin
              cmd.set_err  = 1'b1;
              cmd.err_code = rpnsm_pkg::ERR_READ_REF;
            end else if (!status.ent_ok) begin
              cmd.set_err  = 1'b1;
              cmd.err_code = rpnsm_pkg::ERR_ADDR;
            end else begin
              cmd.mem_write    = 1'b1;
              cmd.mem_src_read = 1'b1;
            end
          end
          rpnsm_pkg::OP_PRINT: begin
            if (status.ent_str) begin
              cmd.print_str = 1'b1;
            end else if (status.ent_ref && !status.ent_ok) begin
              cmd.set_err  = 1'b1;
              cmd.err_code = rpnsm_pkg::ERR_ADDR;
            end else if (status.ent_ref) begin
              state_next = ST_PMEM;
            end else begin
              cmd.print_num = 1'b1;
            end
          end
          default: state_next = ST_FIN;
        endcase
      end
      ST_PMEM: begin
        cmd.print_num = 1'b1;
        cmd.print_mem = 1'b1;
        state_next    = ST_FIN;
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        if (status.mul_last) begin
          state_next = ST_MULF;
        end
      end
      ST_MULF: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = rpnsm_pkg::RES_MUL;
        state_next   = ST_PUSH;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_DIVF;
        end
      end
      ST_DIVF: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = rpnsm_pkg::RES_DIV;
        state_next   = ST_PUSH;
      end
      ST_PUSH: begin
        if (status.stack_full) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = rpnsm_pkg::ERR_FULL;
        end else begin
          cmd.push = 1'b1;
        end
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      pop_n <= 1'b0;
    end else begin
      state <= state_next;
      pop_n <= pop_n_next;
    end
  end

endmodule

// ----- rtl/rpnsm_dpath.sv -----
// datapath: operand stack, data memory, alu, multiply and divide units, result register
module rpnsm_dpath #(
  parameter int MEM_WORDS   = rpnsm_pkg::MEM_WORDS_DEF,
  parameter int STACK_DEPTH = rpnsm_pkg::STACK_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  rpnsm_pkg::cmd_t           cmd,
  output rpnsm_pkg::status_t        status,
  input  logic [2:0]                req_type,
  input  logic [4:0]                opcode,
  input  logic [9:0]                var_address,
  input  logic signed [63:0]        const_value,
  input  logic [15:0]               label_value,
  input  logic [7:0]                string_index,
  input  logic signed [63:0]        read_value,
  input  logic                      cfg_valid,
  input  logic [rpnsm_pkg::CFG_W-1:0] cfg_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      jump_taken,
  output logic [15:0]               jump_target,
  output logic                      print_valid,
  output logic                      print_is_string,
  output logic [7:0]                print_string_index,
  output logic signed [63:0]        print_value,
  output logic                      print_is_whole,
  output logic [2:0]                error_code,
  output logic                      halted
);

  localparam int MAW = $clog2(MEM_WORDS);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int CW  = $clog2(STACK_DEPTH + 1);
  localparam int AW  = rpnsm_pkg::ADDR_W;
  localparam int SUM_W = AW + 17;
  localparam logic [AW:0] MEM_LIM = (AW + 1)'(MEM_WORDS);

  // instruction register
  logic [2:0]         i_req_type;
  logic [4:0]         i_opcode;
  logic [9:0]         i_var_address;
  logic signed [63:0] i_const;
  logic [15:0]        i_label;
  logic [7:0]         i_sidx;
  logic signed [63:0] i_read;

  logic [rpnsm_pkg::CFG_W-1:0] mem_words;
  logic [CW-1:0]               count;
  logic [CW-1:0]               count_m1;
  rpnsm_pkg::entry_t           ent, res, st_rdata;
  logic signed [63:0]          v1, v2;
  logic [63:0]                 dm_rdata;
  logic [MAW-1:0]              clr_cnt;
  logic                        halted_flag;
  logic [2:0]                  halt_code;

  // result of the current request
  logic               w_jump, w_pv, w_pstr, w_pwhole;
  logic [15:0]        w_target;
  logic [7:0]         w_pidx;
  logic signed [63:0] w_pval;

  logic [AW:0]              lim;
  logic signed [31:0]       ip;
  logic signed [SUM_W-1:0]  idx_sum;
  logic signed [63:0]       alu_res;
  logic signed [63:0]       num_src;

  // multiply unit
  logic [2:0]   mul_cnt;
  logic [63:0]  mx, my, pp;
  logic [1:0]   pp_sh;
  logic [127:0] acc;
  logic [31:0]  xp, yp;
  logic [127:0] pp_wide;
  logic signed [63:0] mul_res;

  // divide unit
  logic [63:0] dv_rem, dv_q, dv_n, dv_d;
  logic        dv_ovf;
  logic [6:0]  dv_cnt;
  logic [64:0] r2, r2_sub;
  logic        r2_ge, rnd;
  logic [63:0] q_rnd;
  logic signed [63:0] div_res;

  logic              dm_we;
  logic [MAW-1:0]    dm_waddr;
  logic [63:0]       dm_wdata;

  assign count_m1 = count - CW'(1);

  rpnsm_ram #(.W($bits(rpnsm_pkg::entry_t)), .D(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (count[SAW-1:0]),
    .wdata (res),
    .raddr (count_m1[SAW-1:0]),
    .rdata (st_rdata)
  );

  always_comb begin
    dm_we    = cmd.clear_step | cmd.mem_write;
    dm_waddr = cmd.clear_step ? clr_cnt : ent.addr[MAW-1:0];
    dm_wdata = cmd.clear_step ? 64'd0 : (cmd.mem_src_read ? i_read : v1);
  end

  rpnsm_ram #(.W(64), .D(MEM_WORDS)) u_dmem (
    .clk   (clk),
    .we    (dm_we),
    .waddr (dm_waddr),
    .wdata (dm_wdata),
    .raddr (ent.addr[MAW-1:0]),
    .rdata (dm_rdata)
  );

  always_comb begin
    lim     = ((AW + 1)'(mem_words) < MEM_LIM) ? (AW + 1)'(mem_words) : MEM_LIM;
    ip      = rpnsm_pkg::int_part(v1);
    idx_sum = SUM_W'($signed({1'b0, ent.addr})) + SUM_W'(ip);
    num_src = cmd.print_mem ? $signed(dm_rdata) : ent.val;
  end

  always_comb begin
    case (i_opcode)
      rpnsm_pkg::OP_ADD: alu_res = rpnsm_pkg::sat65({v2[63], v2} + {v1[63], v1});
      rpnsm_pkg::OP_SUB: alu_res = rpnsm_pkg::sat65({v2[63], v2} - {v1[63], v1});
      rpnsm_pkg::OP_NEG: alu_res = (v1 == rpnsm_pkg::Q_MIN) ? rpnsm_pkg::Q_MAX : -v1;
      rpnsm_pkg::OP_LT:  alu_res = (v2 <  v1) ? rpnsm_pkg::ONE_Q : 64'sd0;
      rpnsm_pkg::OP_GT:  alu_res = (v2 >  v1) ? rpnsm_pkg::ONE_Q : 64'sd0;
      rpnsm_pkg::OP_LE:  alu_res = (v2 <= v1) ? rpnsm_pkg::ONE_Q : 64'sd0;
      rpnsm_pkg::OP_GE:  alu_res = (v2 >= v1) ? rpnsm_pkg::ONE_Q : 64'sd0;
      rpnsm_pkg::OP_EQ:  alu_res = (v2 == v1) ? rpnsm_pkg::ONE_Q : 64'sd0;
      rpnsm_pkg::OP_NE:  alu_res = (v2 != v1) ? rpnsm_pkg::ONE_Q : 64'sd0;
      default:           alu_res = 64'sd0;
    endcase
  end

  // multiply: four 32x32 partial products, rounding constant preloaded
  always_comb begin
    xp = mul_cnt[1] ? mx[63:32] : mx[31:0];
    yp = mul_cnt[0] ? my[63:32] : my[31:0];
    case (pp_sh)
      2'd0:    pp_wide = {64'd0, pp};
      2'd1:    pp_wide = {32'd0, pp, 32'd0};
      default: pp_wide = {pp, 64'd0};
    endcase
    mul_res = rpnsm_pkg::from_mag(acc[95:32], v2[63] ^ v1[63], |acc[127:96]);
  end

  // divide: one restoring step a cycle, then round half away from zero
  always_comb begin
    r2      = {dv_rem, dv_n[63]};
    r2_sub  = r2 - {1'b0, dv_d};
    r2_ge   = r2 >= {1'b0, dv_d};
    rnd     = {dv_rem, 1'b0} >= {1'b0, dv_d};
    q_rnd   = dv_q + {63'd0, rnd};
    div_res = rpnsm_pkg::from_mag(q_rnd, v2[63] ^ v1[63], dv_ovf | (rnd & (&dv_q)));
  end

  always_ff @(posedge clk) begin
    if (cmd.load_instr) begin
      i_req_type    <= req_type;
      i_opcode      <= opcode;
      i_var_address <= var_address;
      i_const       <= const_value;
      i_label       <= label_value;
      i_sidx        <= string_index;
      i_read        <= read_value;
    end
    if (cmd.ent_load) begin
      ent <= st_rdata;
    end
    if (cmd.slot_load) begin
      if (cmd.slot_sel) begin
        v2 <= cmd.slot_mem ? $signed(dm_rdata) : ent.val;
      end else begin
        v1 <= cmd.slot_mem ? $signed(dm_rdata) : ent.val;
      end
    end
    if (cmd.res_load) begin
      res <= '0;
      case (cmd.res_sel)
        rpnsm_pkg::RES_VAR: begin
          res.is_ref <= 1'b1;
          res.addr   <= AW'(i_var_address);
        end
        rpnsm_pkg::RES_CONST: res.val <= i_const;
        rpnsm_pkg::RES_STR: begin
          res.is_ref <= 1'b1;
          res.is_str <= 1'b1;
          res.addr   <= AW'(i_sidx);
        end
        rpnsm_pkg::RES_LABEL: res.val <= $signed({16'd0, i_label, 32'd0});
        rpnsm_pkg::RES_ALU:   res.val <= alu_res;
        rpnsm_pkg::RES_MUL:   res.val <= mul_res;
        rpnsm_pkg::RES_DIV:   res.val <= div_res;
        rpnsm_pkg::RES_IDX: begin
          res.is_ref <= 1'b1;
          res.addr   <= idx_sum[AW-1:0];
        end
        default: res <= '0;
      endcase
    end
    if (cmd.mul_start) begin
      mx  <= rpnsm_pkg::magnitude(v2);
      my  <= rpnsm_pkg::magnitude(v1);
      acc <= 128'h8000_0000;
    end else if (cmd.mul_step) begin
      if (mul_cnt < 3'd4) begin
        pp    <= xp * yp;
        pp_sh <= {1'b0, mul_cnt[1]} + {1'b0, mul_cnt[0]};
      end
      if (mul_cnt != 3'd0) begin
        acc <= acc + pp_wide;
      end
    end
    if (cmd.div_start) begin
      dv_rem <= 64'd0;
      dv_q   <= 64'd0;
      dv_n   <= rpnsm_pkg::magnitude(v2);
      dv_d   <= rpnsm_pkg::magnitude(v1);
      dv_ovf <= 1'b0;
    end else if (cmd.div_step) begin
      dv_rem <= r2_ge ? r2_sub[63:0] : r2[63:0];
      dv_q   <= {dv_q[62:0], r2_ge};
      dv_ovf <= dv_ovf | dv_q[63];
      dv_n   <= {dv_n[62:0], 1'b0};
    end
    if (cmd.load_instr) begin
      w_jump   <= 1'b0;
      w_target <= 16'd0;
      w_pv     <= 1'b0;
      w_pstr   <= 1'b0;
      w_pidx   <= 8'd0;
      w_pval   <= 64'sd0;
      w_pwhole <= 1'b0;
    end else begin
      if (cmd.jump) begin
        w_jump   <= 1'b1;
        w_target <= ip[15:0];
      end
      if (cmd.print_str) begin
        w_pv   <= 1'b1;
        w_pstr <= 1'b1;
        w_pidx <= ent.addr[7:0];
      end
      if (cmd.print_num) begin
        w_pv     <= 1'b1;
        w_pval   <= num_src;
        w_pwhole <= (num_src[31:0] == 32'd0);
      end
    end
    if (cmd.out_load) begin
      jump_taken         <= halted_flag ? 1'b0 : w_jump;
      jump_target        <= halted_flag ? 16'd0 : w_target;
      print_valid        <= halted_flag ? 1'b0 : w_pv;
      print_is_string    <= halted_flag ? 1'b0 : w_pstr;
      print_string_index <= halted_flag ? 8'd0 : w_pidx;
      print_value        <= halted_flag ? 64'sd0 : w_pval;
      print_is_whole     <= halted_flag ? 1'b0 : w_pwhole;
      error_code         <= halted_flag ? halt_code : rpnsm_pkg::ERR_NONE;
      halted             <= halted_flag;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      mem_words   <= rpnsm_pkg::CFG_RESET;
      count       <= '0;
      clr_cnt     <= '0;
      halted_flag <= 1'b0;
      halt_code   <= rpnsm_pkg::ERR_NONE;
      mul_cnt     <= '0;
      dv_cnt      <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        mem_words <= cfg_data;
      end
      if (cmd.pop) begin
        count <= count_m1;
      end else if (cmd.push) begin
        count <= count + CW'(1);
      end
      if (cmd.clear_step) begin
        clr_cnt <= clr_cnt + MAW'(1);
      end
      if (cmd.set_err) begin
        halted_flag <= 1'b1;
        halt_code   <= cmd.err_code;
      end
      if (cmd.mul_start) begin
        mul_cnt <= '0;
      end else if (cmd.mul_step) begin
        mul_cnt <= mul_cnt + 3'd1;
      end
      if (cmd.div_start) begin
        dv_cnt <= '0;
      end else if (cmd.div_step) begin
        dv_cnt <= dv_cnt + 7'd1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    status.req_type    = i_req_type;
    status.opcode      = i_opcode;
    status.halted      = halted_flag;
    status.stack_empty = (count == '0);
    status.stack_full  = (count == CW'(STACK_DEPTH));
    status.ent_ref     = ent.is_ref;
    status.ent_str     = ent.is_str;
    status.ent_ok      = ({1'b0, ent.addr} < lim);
    status.v1_zero     = (v1 == 64'sd0);
    status.v2_zero     = (v2 == 64'sd0);
    status.idx_ok      = !idx_sum[SUM_W-1] && (idx_sum[SUM_W-2:0] < (SUM_W - 1)'(lim));
    status.mul_last    = (mul_cnt == 3'd4);
    status.div_last    = (dv_cnt == 7'(rpnsm_pkg::DIV_STEPS - 1));
    status.clear_last  = (clr_cnt == MAW'(MEM_WORDS - 1));
    status.out_free    = !out_valid || !out_stall;
  end

endmodule

// ----- rtl/rpn_stack_machine_executor.sv -----
// top level of the rpn stack machine executor
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+--------------------------------------------
//  in      | request   | in_valid / in_stall   | req_type opcode var_address const_value
//          |           |                       | label_value string_index read_value
//  out     | result    | out_valid / out_stall | jump_taken jump_target print_* error_code
//          |           |                       | halted
//  cfg     | write     | cfg_valid / cfg_ready | cfg_data (mem_words_in_use)
//
// one request at a time: a push is decoded and then pushed, a binary operation pops twice
// (each pop is a stack ram read, plus a data memory read for a reference), mul adds the
// steps for the four 32x32 partial products, div adds the steps of the bit-serial divider.
// after reset the data memory is zeroed one word a cycle, with in_stall high.
// the result register lets the next request start while the last result is stalled.
// an error halts the machine; later requests return the same error code until reset.
module rpn_stack_machine_executor #(
  parameter int MEM_WORDS   = rpnsm_pkg::MEM_WORDS_DEF,
  parameter int STACK_DEPTH = rpnsm_pkg::STACK_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    req_type,
  input  logic [4:0]                    opcode,
  input  logic [9:0]                    var_address,
  input  logic signed [63:0]            const_value,
  input  logic [15:0]                   label_value,
  input  logic [7:0]                    string_index,
  input  logic signed [63:0]            read_value,
  // configuration write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rpnsm_pkg::CFG_W-1:0]   cfg_data,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          jump_taken,
  output logic [15:0]                   jump_target,
  output logic                          print_valid,
  output logic                          print_is_string,
  output logic [7:0]                    print_string_index,
  output logic signed [63:0]            print_value,
  output logic                          print_is_whole,
  output logic [2:0]                    error_code,
  output logic                          halted
);

  rpnsm_pkg::cmd_t    cmd;
  rpnsm_pkg::status_t status;

  // the single register can always be written
  assign cfg_ready = 1'b1;

  // sequencer: clear pass, pops, operation steps, result hand-off
  rpnsm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // stack, data memory, arithmetic and result register
  rpnsm_dpath #(
    .MEM_WORDS   (MEM_WORDS),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .status             (status),
    .req_type           (req_type),
    .opcode             (opcode),
    .var_address        (var_address),
    .const_value        (const_value),
    .label_value        (label_value),
    .string_index       (string_index),
    .read_value         (read_value),
    .cfg_valid          (cfg_valid),
    .cfg_data           (cfg_data),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .jump_taken         (jump_taken),
    .jump_target        (jump_target),
    .print_valid        (print_valid),
    .print_is_string    (print_is_string),
    .print_string_index (print_string_index),
    .print_value        (print_value),
    .print_is_whole     (print_is_whole),
    .error_code         (error_code),
    .halted             (halted)
  );

endmodule

// ----- tb/tb_top.sv -----
// self-checking testbench for the rpn stack machine executor
`timescale 1ns / 1ps

module tb_top;
  import rpnsm_pkg::*;

  // one instruction as driven on the request channel
  typedef struct {
    logic [2:0]         rt;
    logic [4:0]         op;
    logic [9:0]         va;
    logic signed [63:0] cv;
    logic [15:0]        lv;
    logic [7:0]         si;
    logic signed [63:0] rv;
  } instr_t;

  // one result as seen on the result channel
  typedef struct packed {
    logic               jump_taken;
    logic [15:0]        jump_target;
    logic               print_valid;
    logic               print_is_string;
    logic [7:0]         print_string_index;
    logic signed [63:0] print_value;
    logic               print_is_whole;
    logic [2:0]         error_code;
    logic               halted;
  } outcome_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [2:0] req_type;
  logic [4:0] opcode;
  logic [9:0] var_address;
  logic signed [63:0] const_value;
  logic [15:0] label_value;
  logic [7:0] string_index;
  logic signed [63:0] read_value;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_data;
  logic out_valid;
  logic out_stall;
  outcome_t seen;

  rpn_stack_machine_executor u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .opcode(opcode), .var_address(var_address),
    .const_value(const_value), .label_value(label_value),
    .string_index(string_index), .read_value(read_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .jump_taken(seen.jump_taken), .jump_target(seen.jump_target),
    .print_valid(seen.print_valid), .print_is_string(seen.print_is_string),
    .print_string_index(seen.print_string_index), .print_value(seen.print_value),
    .print_is_whole(seen.print_is_whole), .error_code(seen.error_code),
    .halted(seen.halted)
  );

  // ---------------------------------------------------------------------------
  // machine state mirrored by the predictor
  // ---------------------------------------------------------------------------
  entry_t             opnd_stack[64];
  int                 depth;
  logic signed [63:0] var_mem[1024];
  bit                 is_halted;
  logic [2:0]         halt_err;
  logic [10:0]        words_limit;

  outcome_t expected_outcomes[$];
  int       fail_count;
  int       send_idle;
  int       recv_stall;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #50_000_000;
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // fixed-point arithmetic of the predictor
  // ---------------------------------------------------------------------------
  function automatic logic signed [63:0] clamp65(input logic signed [64:0] s);
    if (s > $signed({1'b0, Q_MAX})) return Q_MAX;
    if (s < $signed({1'b1, Q_MIN})) return Q_MIN;
    return s[63:0];
  endfunction

  // rebuild a signed value from magnitude and sign, saturating on overflow
  function automatic logic signed [63:0] sat_mag(input logic [63:0] mag, input logic neg,
                                                 input logic ovf);
    if (ovf || mag[63]) return neg ? Q_MIN : Q_MAX;
    return neg ? $signed(64'd0 - mag) : $signed(mag);
  endfunction

  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    return v[63] ? 64'd0 - v : v;
  endfunction

  // product rounded to nearest, ties away from zero
  function automatic logic signed [63:0] q_mul(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
    logic [127:0] p;
    p = {64'd0, abs64(a)} * {64'd0, abs64(b)};
    p = p + 128'h8000_0000;
    return sat_mag(p[95:32], a[63] ^ b[63], |p[127:96]);
  endfunction

  function automatic logic signed [63:0] q_div(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
    logic [127:0] num, dd, q, r;
    num = {32'd0, abs64(a), 32'd0};
    dd  = {64'd0, abs64(b)};
    q   = num / dd;
    r   = num % dd;
    if (r >= dd - r) q = q + 128'd1;
    return sat_mag(q[63:0], a[63] ^ b[63], |q[127:64]);
  endfunction

  // integer part, truncated toward zero
  function automatic longint trunc_int(input logic signed [63:0] v);
    logic [63:0] m;
    if (!v[63]) return v >>> 32;
    m = 64'd0 - v;
    return -longint'({32'd0, m[63:32]});
  endfunction

  function automatic bit addr_valid(input longint a);
    longint lim;
    lim = words_limit < 11'd1024 ? longint'(words_limit) : 1024;
    return a >= 0 && a < lim;
  endfunction

  function automatic entry_t num_entry(input logic signed [63:0] v);
    return '{val: v, is_ref: 1'b0, is_str: 1'b0, addr: '0};
  endfunction

  task automatic push_entry(input entry_t e, output logic [2:0] err);
    err = ERR_NONE;
    if (depth >= 64) err = ERR_FULL;
    else begin
      opnd_stack[depth] = e;
      depth++;
    end
  endtask

  task automatic pop_entry(output entry_t e, output logic [2:0] err);
    err = ERR_NONE;
    e = '0;
    if (depth == 0) err = ERR_EMPTY;
    else begin
      depth--;
      e = opnd_stack[depth];
    end
  endtask

  // pop something that must act as a number
  task automatic pop_num(output logic signed [63:0] v, output logic [2:0] err);
    entry_t e;
    v = 0;
    pop_entry(e, err);
    if (err != ERR_NONE) return;
    if (e.is_str) err = ERR_ADDR;
    else if (e.is_ref) begin
      if (!addr_valid(e.addr)) err = ERR_ADDR;
      else v = var_mem[e.addr];
    end else v = e.val;
  endtask

  // ---------------------------------------------------------------------------
  // predictor: executes one instruction and gives its result
  // ---------------------------------------------------------------------------
  task automatic exec_instr(input instr_t it, output outcome_t res);
    entry_t e;
    logic signed [63:0] a, b, v, c;
    logic signed [64:0] s;
    logic [2:0] err;
    longint ta;
    res = '0;
    err = ERR_NONE;
    a = 0; b = 0; v = 0; c = 0; s = 0; e = '0;
    if (is_halted) begin
      res.error_code = halt_err;
      res.halted = 1'b1;
      return;
    end
    case (it.rt)
      RT_VAR:   push_entry('{val: 0, is_ref: 1'b1, is_str: 1'b0, addr: 17'(it.va)}, err);
      RT_CONST: push_entry(num_entry(it.cv), err);
      RT_STR:   push_entry('{val: 0, is_ref: 1'b1, is_str: 1'b1, addr: 17'(it.si)}, err);
      RT_LABEL: push_entry(num_entry({16'd0, it.lv, 32'd0}), err);
      RT_OP: begin
        case (it.op)
          OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_LT, OP_GT, OP_LE, OP_GE, OP_EQ, OP_NE: begin
            pop_num(b, err);
            if (err == ERR_NONE) pop_num(a, err);
            if (err == ERR_NONE) begin
              s = a;
              case (it.op)
                OP_ADD: v = clamp65(s + b);
                OP_SUB: v = clamp65(s - b);
                OP_MUL: v = q_mul(a, b);
                OP_DIV: begin
                  if (b == 0) err = ERR_DIV_ZERO;
                  else v = q_div(a, b);
                end
                OP_LT:  v = (a < b) ? ONE_Q : 64'sd0;
                OP_GT:  v = (a > b) ? ONE_Q : 64'sd0;
                OP_LE:  v = (a <= b) ? ONE_Q : 64'sd0;
                OP_GE:  v = (a >= b) ? ONE_Q : 64'sd0;
                OP_EQ:  v = (a == b) ? ONE_Q : 64'sd0;
                default: v = (a != b) ? ONE_Q : 64'sd0;
              endcase
              if (err == ERR_NONE) push_entry(num_entry(v), err);
            end
          end
          OP_NEG: begin
            pop_num(v, err);
            if (err == ERR_NONE) push_entry(num_entry(v == Q_MIN ? Q_MAX : -v), err);
          end
          OP_ASSIGN: begin
            pop_num(v, err);
            if (err == ERR_NONE) pop_entry(e, err);
            if (err == ERR_NONE && !e.is_ref) err = ERR_NEED_REF;
            if (err == ERR_NONE && (e.is_str || !addr_valid(e.addr))) err = ERR_ADDR;
            if (err == ERR_NONE) var_mem[e.addr] = v;
          end
          OP_IDX: begin
            pop_num(v, err);
            if (err == ERR_NONE) pop_entry(e, err);
            if (err == ERR_NONE && (!e.is_ref || e.is_str)) err = ERR_ARRAY_REF;
            if (err == ERR_NONE) begin
              ta = longint'(e.addr) + trunc_int(v);
              if (!addr_valid(ta)) err = ERR_ADDR;
              else push_entry('{val: 0, is_ref: 1'b1, is_str: 1'b0, addr: ta[16:0]}, err);
            end
          end
          OP_JF: begin
            pop_num(v, err);
            if (err == ERR_NONE) pop_num(c, err);
            if (err == ERR_NONE && c == 0) begin
              ta = trunc_int(v);
              res.jump_taken = 1'b1;
              res.jump_target = ta[15:0];
            end
          end
          OP_J: begin
            pop_num(v, err);
            if (err == ERR_NONE) begin
              ta = trunc_int(v);
              res.jump_taken = 1'b1;
              res.jump_target = ta[15:0];
            end
          end
          OP_READ: begin
            pop_entry(e, err);
            if (err == ERR_NONE && (!e.is_ref || e.is_str)) err = ERR_READ_REF;
            if (err == ERR_NONE && !addr_valid(e.addr)) err = ERR_ADDR;
            if (err == ERR_NONE) var_mem[e.addr] = it.rv;
          end
          OP_PRINT: begin
            pop_entry(e, err);
            if (err == ERR_NONE) begin
              if (e.is_str) begin
                res.print_valid = 1'b1;
                res.print_is_string = 1'b1;
                res.print_string_index = e.addr[7:0];
              end else if (e.is_ref && !addr_valid(e.addr)) err = ERR_ADDR;
              else begin
                v = e.is_ref ? var_mem[e.addr] : e.val;
                res.print_valid = 1'b1;
                res.print_value = v;
                res.print_is_whole = (v[31:0] == 32'd0);
              end
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    if (err != ERR_NONE) begin
      res = '0;
      is_halted = 1'b1;
      halt_err = err;
      res.error_code = err;
      res.halted = 1'b1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------
  function automatic void cmp_field(input string name, input logic [63:0] exp_v,
                                    input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t mismatch %s expected %h actual %h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_outcomes.size() == 0) begin
        $display("%0t mismatch unexpected result expected none actual %h", $time, seen);
        fail_count++;
      end else begin
        want = expected_outcomes.pop_front();
        cmp_field("jump_taken", want.jump_taken, seen.jump_taken);
        cmp_field("jump_target", want.jump_target, seen.jump_target);
        cmp_field("print_valid", want.print_valid, seen.print_valid);
        cmp_field("print_is_string", want.print_is_string, seen.print_is_string);
        cmp_field("print_string_index", want.print_string_index, seen.print_string_index);
        cmp_field("print_value", want.print_value, seen.print_value);
        cmp_field("print_is_whole", want.print_is_whole, seen.print_is_whole);
        cmp_field("error_code", want.error_code, seen.error_code);
        cmp_field("halted", want.halted, seen.halted);
      end
    end
  end

  // receiver backpressure, redrawn every cycle
  always @(negedge clk) out_stall = ($urandom_range(99) < recv_stall);

  // ---------------------------------------------------------------------------
  // request driving
  // ---------------------------------------------------------------------------
  function automatic instr_t filler();
    instr_t it;
    it.rt = 3'($urandom);
    it.op = 5'($urandom);
    it.va = 10'($urandom);
    it.cv = {$urandom, $urandom};
    it.lv = 16'($urandom);
    it.si = 8'($urandom);
    it.rv = {$urandom, $urandom};
    return it;
  endfunction

  task automatic send_instr(input instr_t it);
    outcome_t res;
    // random idle cycles before the request
    if ($urandom_range(99) < send_idle) begin
      @(negedge clk);
      in_valid = 1'b0;
      while ($urandom_range(99) < send_idle) @(negedge clk);
    end
    @(negedge clk);
    req_type = it.rt;
    opcode = it.op;
    var_address = it.va;
    const_value = it.cv;
    label_value = it.lv;
    string_index = it.si;
    read_value = it.rv;
    in_valid = 1'b1;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    exec_instr(it, res);
    expected_outcomes.push_back(res);
  endtask

  task automatic push_const(input logic signed [63:0] v);
    instr_t it;
    it = filler();
    it.rt = RT_CONST;
    it.cv = v;
    send_instr(it);
  endtask

  task automatic push_var(input logic [9:0] a);
    instr_t it;
    it = filler();
    it.rt = RT_VAR;
    it.va = a;
    send_instr(it);
  endtask

  task automatic push_label(input logic [15:0] l);
    instr_t it;
    it = filler();
    it.rt = RT_LABEL;
    it.lv = l;
    send_instr(it);
  endtask

  task automatic push_str(input logic [7:0] s);
    instr_t it;
    it = filler();
    it.rt = RT_STR;
    it.si = s;
    send_instr(it);
  endtask

  task automatic do_op(input logic [4:0] op);
    instr_t it;
    it = filler();
    it.rt = RT_OP;
    it.op = op;
    send_instr(it);
  endtask

  // pause until every result is back
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [10:0] w);
    drain();
    @(negedge clk);
    cfg_data = w;
    cfg_valid = 1'b1;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    words_limit = w;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // stack inspection for legal program generation
  // ---------------------------------------------------------------------------
  function automatic bit usable(input int k);
    entry_t e;
    if (depth <= k) return 1'b0;
    e = opnd_stack[depth-1-k];
    return !e.is_str && (!e.is_ref || addr_valid(e.addr));
  endfunction

  function automatic bit is_var_ref(input int k);
    entry_t e;
    if (depth <= k) return 1'b0;
    e = opnd_stack[depth-1-k];
    return e.is_ref && !e.is_str && addr_valid(e.addr);
  endfunction

  function automatic logic signed [63:0] peek_val(input int k);
    entry_t e;
    e = opnd_stack[depth-1-k];
    return e.is_ref ? var_mem[e.addr] : e.val;
  endfunction

  function automatic logic signed [63:0] pick_const();
    case ($urandom_range(0, 6))
      0, 1: return {32'($signed($urandom_range(0, 16)) - 8), 32'd0};
      2:    return {$urandom, $urandom};
      3:    return Q_MIN;
      4:    return Q_MAX;
      5:    return 64'sd0;
      default: return {32'($signed($urandom_range(0, 8)) - 4), $urandom};
    endcase
  endfunction

  // pick an instruction that cannot fault in the current state
  function automatic instr_t legal_instr();
    instr_t it;
    bit ok;
    int lim;
    it = filler();
    lim = words_limit < 11'd1024 ? int'(words_limit) : 1024;
    forever begin
      if (depth < 64 && (depth < 2 || $urandom_range(99) < 40)) begin
        it.rt = 3'($urandom_range(0, 3));
        if (it.rt == RT_VAR && lim == 0) it.rt = RT_CONST;
        if (it.rt == RT_VAR) it.va = 10'($urandom_range(0, lim - 1));
        if (it.rt == RT_CONST) it.cv = pick_const();
        return it;
      end
      it.rt = RT_OP;
      it.op = 5'($urandom_range(0, 16));
      case (it.op)
        OP_DIV:    ok = usable(0) && usable(1) && peek_val(0) != 0;
        OP_NEG, OP_J: ok = usable(0);
        OP_ASSIGN: ok = usable(0) && is_var_ref(1);
        OP_IDX:    ok = usable(0) && is_var_ref(1) &&
                        addr_valid(longint'(opnd_stack[depth-2].addr) + trunc_int(peek_val(0)));
        OP_READ:   ok = is_var_ref(0);
        OP_PRINT:  ok = depth > 0 && (opnd_stack[depth-1].is_str || usable(0));
        default:   ok = usable(0) && usable(1);
      endcase
      if (ok) return it;
    end
  endfunction

  // pop everything left so a new limit cannot strand a reference
  task automatic empty_stack();
    while (depth > 0) do_op(OP_PRINT);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // extremes of the values and every operation but gt, le, ge, eq and ne once
  task automatic test_directed();
    instr_t it;
    push_const(Q_MAX);
    push_const(Q_MAX);
    do_op(OP_ADD);                      // saturates high
    do_op(OP_PRINT);
    push_const(64'sd0);
    push_const(Q_MIN);
    do_op(OP_SUB);                      // 0 - min saturates
    do_op(OP_NEG);
    push_var(10'd1023);
    push_const(Q_MIN);
    do_op(OP_ASSIGN);
    push_str(8'd255);
    do_op(OP_PRINT);                    // string print
    push_var(10'd1023);
    push_const(Q_MAX);
    do_op(OP_MUL);                      // saturates low
    push_const(64'sd1);
    do_op(OP_DIV);                      // divide by tiny fraction
    do_op(OP_LT);
    push_label(16'hFFFF);
    do_op(OP_JF);                       // false condition takes the jump
    push_var(10'd0);
    push_const(64'sh0000_0003_8000_0000);
    do_op(OP_IDX);
    do_op(OP_READ);
    push_var(10'd3);
    do_op(OP_PRINT);
    push_label(16'd40000);
    do_op(OP_J);
    // ignored request type and opcode
    it = filler();
    it.rt = 3'd7;
    send_instr(it);
    it = filler();
    it.rt = RT_OP;
    it.op = 5'd31;
    send_instr(it);
  endtask

  // fill the stack to its depth and unwind it
  task automatic test_stack_depth();
    repeat (32) push_label(16'($urandom));
    repeat (32) push_str(8'($urandom));
    repeat (64) do_op(OP_PRINT);
  endtask

  task automatic test_random_programs(input int n);
    instr_t it;
    int done;
    done = 0;
    while (done < n) begin
      if ($urandom_range(99) < 4) begin
        // ignored requests mixed in as noise
        it = filler();
        if ($urandom_range(1)) it.rt = 3'($urandom_range(5, 7));
        else begin
          it.rt = RT_OP;
          it.op = 5'($urandom_range(17, 31));
        end
      end else begin
        it = legal_instr();
        done++;
      end
      send_instr(it);
    end
    empty_stack();
  endtask

  // one fault, then requests that must all report the halt
  task automatic test_error_halt();
    instr_t it;
    case ($urandom_range(0, 4))
      0: do_op(OP_PRINT);                                  // pop from empty stack
      1: begin push_const(pick_const()); push_const(64'sd0); do_op(OP_DIV); end
      2: begin push_const(pick_const()); push_const(pick_const()); do_op(OP_ASSIGN); end
      3: repeat (65) push_label(16'($urandom));            // stack overflow
      default: begin push_str(8'($urandom)); do_op(OP_NEG); end  // string as number
    endcase
    repeat (5) begin
      it = filler();
      send_instr(it);
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    req_type = '0;
    opcode = '0;
    var_address = '0;
    const_value = '0;
    label_value = '0;
    string_index = '0;
    read_value = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    out_stall = 1'b0;
    fail_count = 0;
    depth = 0;
    is_halted = 1'b0;
    halt_err = ERR_NONE;
    words_limit = CFG_RESET;
    foreach (var_mem[i]) var_mem[i] = '0;
    foreach (opnd_stack[i]) opnd_stack[i] = '0;
    send_idle = 36;
    recv_stall = 85;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_limit(11'd1024);
    test_directed();
    test_stack_depth();
    test_random_programs(330);

    send_idle = 85;
    recv_stall = 36;
    write_limit(11'd2047);
    test_random_programs(330);
    write_limit(11'd16);
    test_random_programs(90);
    write_limit(11'd1);
    test_random_programs(40);

    send_idle = 0;
    recv_stall = 0;
    write_limit(11'd0);
    test_random_programs(40);
    write_limit(11'd1024);
    test_random_programs(220);
    test_error_halt();

    drain();
    repeat (200) @(posedge clk);
    if (fail_count == 0 && expected_outcomes.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
